@@ rtl/core/zbtf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zbtf_pkg
// Shared types and constants for the transmit-request framer.
// ----------------------------------------------------------------------------
package zbtf_pkg;

    localparam logic [7:0]  START_DELIM    = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE_TX  = 8'h10;
    // frame type + id + 64-bit addr + 16-bit addr + radius + options
    localparam logic [15:0] FIXED_DATA_LEN = 16'd14;

    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned APB_DATA_W = 64;

    // register index = paddr[5:3]
    localparam logic [2:0] REG_DEST_LONG  = 3'd0;
    localparam logic [2:0] REG_DEST_SHORT = 3'd1;
    localparam logic [2:0] REG_HOP_RADIUS = 3'd2;
    localparam logic [2:0] REG_TX_OPTIONS = 3'd3;
    localparam logic [2:0] REG_FRAME_ID   = 3'd4;

    localparam logic [63:0] RST_DEST_LONG  = 64'd0;
    localparam logic [15:0] RST_DEST_SHORT = 16'hFFFE;
    localparam logic [7:0]  RST_HOP_RADIUS = 8'd0;
    localparam logic [7:0]  RST_TX_OPTIONS = 8'd0;
    localparam logic [7:0]  RST_FRAME_ID   = 8'd1;

    typedef struct packed {
        logic [63:0] dest_long_address;
        logic [15:0] dest_short_address;
        logic [7:0]  hop_radius;
        logic [7:0]  tx_options;
        logic [7:0]  frame_ident;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/zbtf_msg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zbtf_msg_if
// Message byte channel: valid/ready plus one message byte and its length.
// ----------------------------------------------------------------------------
interface zbtf_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] message_length;

    modport source (output valid, output payload_byte, output message_length, input ready);
    modport sink   (input valid, input payload_byte, input message_length, output ready);
endinterface
`default_nettype wire

@@ rtl/core/zbtf_frame_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zbtf_frame_if
// Frame byte channel: valid/ready plus one frame byte and end marker.
// ----------------------------------------------------------------------------
interface zbtf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/zbtf_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zbtf_cfg_regs
// APB register file holding the header fields (addresses, radius, options, id).
// ----------------------------------------------------------------------------
module zbtf_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [zbtf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [zbtf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [zbtf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output zbtf_pkg::cfg_t                         cfg
);

    zbtf_pkg::cfg_t cfg_reg;
    zbtf_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                zbtf_pkg::REG_DEST_LONG:  cfg_next.dest_long_address  = pwdata;
                zbtf_pkg::REG_DEST_SHORT: cfg_next.dest_short_address = pwdata[15:0];
                zbtf_pkg::REG_HOP_RADIUS: cfg_next.hop_radius         = pwdata[7:0];
                zbtf_pkg::REG_TX_OPTIONS: cfg_next.tx_options         = pwdata[7:0];
                zbtf_pkg::REG_FRAME_ID:   cfg_next.frame_ident        = pwdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            zbtf_pkg::REG_DEST_LONG:  prdata = cfg_reg.dest_long_address;
            zbtf_pkg::REG_DEST_SHORT: prdata = {48'd0, cfg_reg.dest_short_address};
            zbtf_pkg::REG_HOP_RADIUS: prdata = {56'd0, cfg_reg.hop_radius};
            zbtf_pkg::REG_TX_OPTIONS: prdata = {56'd0, cfg_reg.tx_options};
            zbtf_pkg::REG_FRAME_ID:   prdata = {56'd0, cfg_reg.frame_ident};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_long_address  <= zbtf_pkg::RST_DEST_LONG;
            cfg_reg.dest_short_address <= zbtf_pkg::RST_DEST_SHORT;
            cfg_reg.hop_radius         <= zbtf_pkg::RST_HOP_RADIUS;
            cfg_reg.tx_options         <= zbtf_pkg::RST_TX_OPTIONS;
            cfg_reg.frame_ident        <= zbtf_pkg::RST_FRAME_ID;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/zigbee_tx_request_framer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zigbee_tx_request_framer
// Serializes message bytes into API transmit-request frames with checksum.
// ----------------------------------------------------------------------------
// The block emits one frame byte per clock, while an item is held and the
// receiver is ready, through a single output register. A message byte that
// opens a frame produces the 17-byte header (0x7E, length hi/lo = 14 +
// message_length, type 0x10, frame id, 64-bit and 16-bit destination, radius,
// options) followed by the byte itself, plus the checksum on a one-byte
// message. An empty message (message_length 0 at frame start) gives header and
// checksum. A middle byte gives only itself; the closing byte gives the byte
// then the checksum = 0xFF minus the 8-bit sum of everything from the frame
// type on. The next transaction is taken in the same cycle that the current
// item's last byte moves into the output register, so a stream of middle
// bytes runs at one per clock while the receiver is ready. Header fields come
// from the APB registers (64-bit data, register i at byte address 8*i); they
// are meant to be written only while the framer is idle.
// ----------------------------------------------------------------------------
module zigbee_tx_request_framer
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    zbtf_msg_if.sink                               msg,
    zbtf_frame_if.source                           frame,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [zbtf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [zbtf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [zbtf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    // header slot positions within an item that opens a frame
    localparam logic [4:0] SLOT_DELIM    = 5'd0;
    localparam logic [4:0] SLOT_LEN_HI   = 5'd1;
    localparam logic [4:0] SLOT_LEN_LO   = 5'd2;
    localparam logic [4:0] SLOT_TYPE     = 5'd3;
    localparam logic [4:0] SLOT_ID       = 5'd4;
    localparam logic [4:0] SLOT_LONG0    = 5'd5;
    localparam logic [4:0] SLOT_LONG7    = 5'd12;
    localparam logic [4:0] SLOT_SHORT_HI = 5'd13;
    localparam logic [4:0] SLOT_SHORT_LO = 5'd14;
    localparam logic [4:0] SLOT_RADIUS   = 5'd15;
    localparam logic [4:0] SLOT_OPTIONS  = 5'd16;
    localparam logic [4:0] SLOT_BODY     = 5'd17;  // message byte (or checksum if empty)
    localparam logic [4:0] SLOT_CKSUM    = 5'd18;

    zbtf_pkg::cfg_t cfg;

    zbtf_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // held input item
    logic       item_valid_reg, item_valid_next;
    logic       item_hdr_reg,   item_hdr_next;
    logic [7:0] item_pay_reg,   item_pay_next;
    logic [7:0] item_len_reg,   item_len_next;
    logic [4:0] step_reg,       step_next;

    // frame state
    logic [7:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_end_reg,   out_end_next;

    logic        out_space;
    logic        fire;
    logic        accept;
    logic        is_hdr;
    logic        at_body;
    logic        is_pay;
    logic        is_cksum;
    logic        is_last;
    logic        close_frame;
    logic        adds_sum;
    logic [7:0]  pos_inc;
    logic [7:0]  cur_byte;
    logic [7:0]  hdr_byte;
    logic [15:0] total_len;
    logic [2:0]  long_idx;
    logic [5:0]  long_sh;

    // ---- decode of the current step ----
    always_comb
    begin
        is_hdr      = item_hdr_reg && (step_reg < SLOT_BODY);
        at_body     = item_hdr_reg ? (step_reg == SLOT_BODY) : (step_reg == SLOT_DELIM);
        is_pay      = at_body && !(item_hdr_reg && (item_len_reg == 8'd0));
        is_cksum    = (at_body && item_hdr_reg && (item_len_reg == 8'd0))
                    || (item_hdr_reg ? (step_reg == SLOT_CKSUM) : (step_reg == 5'd1));
        pos_inc     = pos_reg + 8'd1;
        close_frame = (pos_inc >= item_len_reg) || (pos_inc == 8'd0);
        is_last     = is_cksum || (is_pay && !close_frame);
        adds_sum    = is_pay || (is_hdr && (step_reg >= SLOT_TYPE));
    end

    // ---- header byte select ----
    always_comb
    begin
        total_len = zbtf_pkg::FIXED_DATA_LEN + {8'd0, item_len_reg};
        long_idx  = 3'd7 - 3'(step_reg - SLOT_LONG0);
        long_sh   = {long_idx, 3'b000};
        case (step_reg)
            SLOT_DELIM:    hdr_byte = zbtf_pkg::START_DELIM;
            SLOT_LEN_HI:   hdr_byte = total_len[15:8];
            SLOT_LEN_LO:   hdr_byte = total_len[7:0];
            SLOT_TYPE:     hdr_byte = zbtf_pkg::FRAME_TYPE_TX;
            SLOT_ID:       hdr_byte = cfg.frame_ident;
            SLOT_SHORT_HI: hdr_byte = cfg.dest_short_address[15:8];
            SLOT_SHORT_LO: hdr_byte = cfg.dest_short_address[7:0];
            SLOT_RADIUS:   hdr_byte = cfg.hop_radius;
            SLOT_OPTIONS:  hdr_byte = cfg.tx_options;
            default:
            begin
                if (step_reg inside {[SLOT_LONG0:SLOT_LONG7]})
                    hdr_byte = cfg.dest_long_address[long_sh +: 8];
                else
                    hdr_byte = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        if (is_hdr)
            cur_byte = hdr_byte;
        else if (is_pay)
            cur_byte = item_pay_reg;
        else
            cur_byte = 8'hFF - sum_reg;
    end

    // ---- handshakes ----
    assign out_space   = !out_valid_reg || frame.ready;
    assign fire        = item_valid_reg && out_space;
    assign msg.ready   = !item_valid_reg || (fire && is_last);
    assign accept      = msg.valid && msg.ready;

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_end  = out_end_reg;

    // ---- next state ----
    always_comb
    begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        step_next       = step_reg;
        item_valid_next = item_valid_reg;
        item_hdr_next   = item_hdr_reg;
        item_pay_next   = item_pay_reg;
        item_len_next   = item_len_reg;
        out_valid_next  = out_valid_reg && !frame.ready;
        out_byte_next   = out_byte_reg;
        out_end_next    = out_end_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_end_next   = is_cksum;
            step_next      = step_reg + 5'd1;
            if (is_hdr && step_reg == SLOT_DELIM)
                sum_next = 8'd0;
            else if (adds_sum)
                sum_next = sum_reg + cur_byte;
            if (is_pay)
                pos_next = pos_inc;
            if (is_cksum)
            begin
                pos_next = 8'd0;
                sum_next = 8'd0;
            end
            if (is_last)
                item_valid_next = 1'b0;
        end

        if (accept)
        begin
            item_valid_next = 1'b1;
            item_hdr_next   = (pos_next == 8'd0);
            item_pay_next   = msg.payload_byte;
            item_len_next   = msg.message_length;
            step_next       = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            item_hdr_reg   <= 1'b0;
            step_reg       <= 5'd0;
            pos_reg        <= 8'd0;
            sum_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            item_hdr_reg   <= item_hdr_next;
            step_reg       <= step_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_pay_reg <= item_pay_next;
        item_len_reg <= item_len_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

    // ---- assertions ----
    // checksum always leaves the frame state cleared
    a_cksum_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_cksum |=> (pos_reg == 8'd0) && (sum_reg == 8'd0))
        else $error("frame state not cleared after checksum");

    // a held item never runs past the checksum slot
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (step_reg <= SLOT_CKSUM))
        else $error("item step out of range");

    // header and body of a frame-opening item start at position zero
    a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && item_hdr_reg && (step_reg <= SLOT_BODY) |-> (pos_reg == 8'd0))
        else $error("header emitted mid-frame");

    // frame end marks only the checksum, produced by the last step of an item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_cksum |-> is_last && !is_pay && !is_hdr)
        else $error("checksum not the last byte of its item");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the transmit-request framer: message bytes go in
// over the msg channel, a local model of the framer predicts every header,
// payload and checksum byte, and a scoreboard checks each frame transaction
// in order. Registers are set over APB between traffic phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CLK_HALF_NS   = 2;
    localparam int          RESET_CYCLES  = 4;
    localparam int          RUN_LIMIT_NS  = 1_000_000;
    localparam int          RANDOM_ITEMS  = 500;
    localparam int          TAIL_CYCLES   = 24;         // > one header burst
    localparam logic [7:0]  CHECKSUM_BASE = 8'hFF;

    typedef enum int {CFG_ZEROS, CFG_ONES, CFG_RANDOM} cfg_style_t;

    // one expected frame byte
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the header registers and of the
    // framing state, expands each accepted message byte into the frame bytes
    // it must produce, and checks frame transactions against them in order.
    // ------------------------------------------------------------------------
    class framer_scoreboard;
        zbtf_pkg::cfg_t regs;
        logic [7:0]     msg_bytes_sent;   // payload bytes in the open frame
        logic [7:0]     data_sum;         // sum of frame-data bytes so far
        frame_beat_t    frame_bytes_due[$];
        int unsigned    mismatches;

        function new();
            regs.dest_long_address  = zbtf_pkg::RST_DEST_LONG;
            regs.dest_short_address = zbtf_pkg::RST_DEST_SHORT;
            regs.hop_radius         = zbtf_pkg::RST_HOP_RADIUS;
            regs.tx_options         = zbtf_pkg::RST_TX_OPTIONS;
            regs.frame_ident        = zbtf_pkg::RST_FRAME_ID;
            msg_bytes_sent = '0;
            data_sum       = '0;
            mismatches     = 0;
        endfunction

        // unmapped indexes fall through and change nothing
        function void write_register(logic [2:0] idx, logic [63:0] value);
            case (idx)
                zbtf_pkg::REG_DEST_LONG:  regs.dest_long_address  = value;
                zbtf_pkg::REG_DEST_SHORT: regs.dest_short_address = value[15:0];
                zbtf_pkg::REG_HOP_RADIUS: regs.hop_radius         = value[7:0];
                zbtf_pkg::REG_TX_OPTIONS: regs.tx_options         = value[7:0];
                zbtf_pkg::REG_FRAME_ID:   regs.frame_ident        = value[7:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] value, logic last, logic summed);
            frame_beat_t beat;
            beat.value = value;
            beat.last  = last;
            frame_bytes_due.push_back(beat);
            if (summed)
                data_sum = data_sum + value;
        endfunction

        function void close_frame();
            push_byte(CHECKSUM_BASE - data_sum, 1'b1, 1'b0);
            msg_bytes_sent = '0;
            data_sum       = '0;
        endfunction

        // expected frame bytes caused by one accepted message byte
        function void note_message_byte(logic [7:0] payload, logic [7:0] msg_len);
            logic [15:0] total_len;
            if (msg_bytes_sent == 8'd0)
            begin
                // header is built from the registers as they stand right now
                data_sum  = '0;
                total_len = zbtf_pkg::FIXED_DATA_LEN + {8'd0, msg_len};
                push_byte(zbtf_pkg::START_DELIM, 1'b0, 1'b0);
                push_byte(total_len[15:8], 1'b0, 1'b0);
                push_byte(total_len[7:0], 1'b0, 1'b0);
                push_byte(zbtf_pkg::FRAME_TYPE_TX, 1'b0, 1'b1);
                push_byte(regs.frame_ident, 1'b0, 1'b1);
                for (int k = 7; k >= 0; k--)
                    push_byte(regs.dest_long_address[k*8 +: 8], 1'b0, 1'b1);
                push_byte(regs.dest_short_address[15:8], 1'b0, 1'b1);
                push_byte(regs.dest_short_address[7:0], 1'b0, 1'b1);
                push_byte(regs.hop_radius, 1'b0, 1'b1);
                push_byte(regs.tx_options, 1'b0, 1'b1);
                if (msg_len == 8'd0)
                begin
                    // empty message: payload byte is dropped
                    close_frame();
                    return;
                end
            end
            push_byte(payload, 1'b0, 1'b1);
            msg_bytes_sent = msg_bytes_sent + 8'd1;
            // length is re-read on every byte, so a shrinking length closes early
            if (msg_bytes_sent >= msg_len || msg_bytes_sent == 8'd0)
                close_frame();
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] frame mismatch: %s", $realtime, what);
        endtask

        task check_frame_byte(logic [7:0] value, logic last);
            frame_beat_t due;
            if (frame_bytes_due.size() == 0)
            begin
                report($sformatf("unexpected byte 0x%02h end=%0b", value, last));
                return;
            end
            due = frame_bytes_due.pop_front();
            if (value !== due.value)
                report($sformatf("frame_byte 0x%02h, expected 0x%02h", value, due.value));
            if (last !== due.last)
                report($sformatf("frame_end %0b, expected %0b", last, due.last));
        endtask

        function int pending();
            return frame_bytes_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [zbtf_pkg::APB_ADDR_W-1:0] paddr;
    logic [zbtf_pkg::APB_DATA_W-1:0] pwdata;
    logic [zbtf_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    zbtf_msg_if   msg_ch();
    zbtf_frame_if frame_ch();

    zigbee_tx_request_framer dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .frame   (frame_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    framer_scoreboard sb = new();

    // idle percentages for the current traffic phase
    int sender_idle_pct  = 0;
    int receiver_stall_pct = 0;
    int items_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #RUN_LIMIT_NS;
        $display("** zigbee_tx_request_framer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame side: values are sampled right after the edge, i.e. as they were
    // at the edge, so a transaction is valid && ready seen here. Ready is
    // re-drawn every cycle from the stall percentage.
    // ------------------------------------------------------------------------
    initial
    begin
        frame_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && frame_ch.valid && frame_ch.ready)
                sb.check_frame_byte(frame_ch.frame_byte, frame_ch.frame_end);
            frame_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Message side and APB tasks. Every task starts and ends just after a
    // rising edge. Valid stays high between back-to-back items; a drain drops
    // it, and register writes only follow a drain.
    // ------------------------------------------------------------------------
    task automatic send_message_byte(input logic [7:0] payload, input logic [7:0] msg_len);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.payload_byte   <= payload;
        msg_ch.message_length <= msg_len;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        sb.note_message_byte(payload, msg_len);
        items_sent++;
    endtask

    // hold the sender off until every predicted frame byte has come out
    task automatic wait_frames_drained();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // setup cycle, then access cycle; the write lands when pready is seen
    task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_registers(input cfg_style_t style);
        logic [63:0] v [5];
        for (int i = 0; i < 5; i++)
        begin
            case (style)
                CFG_ZEROS: v[i] = '0;
                CFG_ONES:  v[i] = '1;
                default:   v[i] = {$urandom, $urandom};
            endcase
        end
        write_register(zbtf_pkg::REG_DEST_LONG,  v[0]);
        write_register(zbtf_pkg::REG_DEST_SHORT, v[1]);
        write_register(zbtf_pkg::REG_HOP_RADIUS, v[2]);
        write_register(zbtf_pkg::REG_TX_OPTIONS, v[3]);
        write_register(zbtf_pkg::REG_FRAME_ID,   v[4]);
    endtask

    // mostly short messages, some empty, a few longer ones
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 8'd0;
        else if (r < 85)
            return 8'($urandom_range(6, 1));
        else if (r < 97)
            return 8'($urandom_range(30, 7));
        else
            return 8'($urandom_range(80, 31));
    endfunction

    // well-formed message: constant length, one item per byte
    task automatic send_message(input logic [7:0] msg_len);
        int count;
        count = (msg_len == 8'd0) ? 1 : int'(msg_len);
        for (int i = 0; i < count; i++)
            send_message_byte(8'($urandom), msg_len);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    int sender_idle_by_phase [4]   = '{0, 57, 0, 23};
    int receiver_stall_by_phase [4] = '{0, 0, 57, 23};

    initial
    begin
        int phase_target;
        int r;

        rst_n                 <= 1'b0;
        msg_ch.valid          <= 1'b0;
        msg_ch.payload_byte   <= '0;
        msg_ch.message_length <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, reset register values first ---
        // empty message: header + checksum, payload ignored
        send_message_byte(8'hFF, 8'd0);
        // one-byte message: header, byte, checksum from a single item
        send_message_byte(8'h00, 8'd1);
        send_message_byte(8'hFF, 8'd2);
        send_message_byte(8'hA5, 8'd2);
        wait_frames_drained();

        // all-ones registers; writes to unmapped indexes must change nothing
        load_registers(CFG_ONES);
        for (int i = int'(zbtf_pkg::REG_FRAME_ID) + 1; i < 8; i++)
            write_register(3'(i), {$urandom, $urandom});
        // max length in the header (high length byte set), then the length
        // drops mid-message and the next byte closes the frame
        send_message_byte(8'h5A, 8'd255);
        send_message_byte(8'hC3, 8'd1);
        send_message_byte(8'h3C, 8'd0);
        wait_frames_drained();

        // registers rewritten while a frame is open: only the next frame sees it
        send_message_byte(8'h11, 8'd3);
        wait_frames_drained();
        load_registers(CFG_ZEROS);
        send_message_byte(8'h22, 8'd3);
        send_message_byte(8'h33, 8'd3);
        send_message_byte(8'h44, 8'd1);

        // length lowered to the number of bytes already sent
        send_message_byte(8'h80, 8'd4);
        send_message_byte(8'h01, 8'd4);
        send_message_byte(8'h7F, 8'd2);
        wait_frames_drained();

        // --- random part, four idle/stall phases ---
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_frames_drained();
            load_registers(phase == 1 ? CFG_ONES : CFG_RANDOM);
            sender_idle_pct    = sender_idle_by_phase[phase];
            receiver_stall_pct = receiver_stall_by_phase[phase];
            phase_target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_target)
            begin
                r = $urandom_range(99);
                if (r < 78)
                    send_message(pick_length());
                else if (r < 96)
                begin
                    // broken sequence: length changes on every item, any value
                    repeat ($urandom_range(4, 1))
                        send_message_byte(8'($urandom), 8'($urandom));
                end
                else
                    wait_frames_drained();
            end
        end

        // --- wrap up ---
        wait_frames_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("** zigbee_tx_request_framer: PASSED **");
        else
            $display("** zigbee_tx_request_framer: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/zbtf_pkg.sv
rtl/core/zbtf_msg_if.sv
rtl/core/zbtf_frame_if.sv
rtl/core/zbtf_cfg_regs.sv
rtl/core/zigbee_tx_request_framer.sv
tb/tb_top.sv
